>>> rtl/adq_pkg.sv
// Shared types, constants and index helpers for the array deque engine.
// Used by adq_core and array_deque_engine_unit; no dependencies.
`default_nettype none

package adq_pkg;

   // Store geometry
   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int OCC_W   = 5;

   // Stream packing
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 104;
   localparam int TUSER_W     = 2;

   localparam logic [WORD_W-1:0] NONE_WORD = '1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      MODE_PUSH_REAR  = 2'd0,
      MODE_PUSH_FRONT = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   // One finished result, handed from the core to the output register
   typedef struct packed {
      status_type       status;
      word_type         popped;
      word_type         front;
      word_type         rear;
      logic [OCC_W-1:0] occupancy;
   } result_type;

   // Circular index step, forward and backward
   function automatic idx_type idx_next(input idx_type i);
      if (i == IDX_W'(DEPTH - 1)) begin
         idx_next = '0;
      end else begin
         idx_next = i + 1'b1;
      end
   endfunction

   function automatic idx_type idx_prev(input idx_type i);
      if (i == '0) begin
         idx_prev = IDX_W'(DEPTH - 1);
      end else begin
         idx_prev = i - 1'b1;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/array_deque_engine_unit.sv
// Array deque engine: a push and an empty or overflow case finish in the core's idle state;
// a pop that leaves words behind also passes through the fetch state, since the new front
// or rear word is read from the store, which has a registered read.
// The result sits in an output register.
// Synchronous reset empties the deque; store contents are not cleared.
`default_nettype none

module array_deque_engine_unit
   import adq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] item
   input  wire logic [TUSER_W-1:0]     req_tuser,  // [1:0] mode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,  // [31:0] popped_value,
                                                    // [63:32] front_value,
                                                    // [95:64] rear_value,
                                                    // [100:96] occupancy
   output logic      [TUSER_W-1:0]     rsp_tuser   // [1:0] status
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       out_free;
   logic       res_valid;
   result_type res;
   logic       wr_en;
   idx_type    wr_addr;
   word_type   wr_data;
   logic       rd_en;
   idx_type    rd_addr;
   word_type   rd_data;

   assign out_free = !rsp_valid_ff || rsp_tready;

   adq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (mode_type'(req_tuser[1:0])),
      .req_item  (req_tdata[WORD_W-1:0]),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   adq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: loads a finished request, drops when taken
   always_comb begin
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'b000, rsp_ff.occupancy, rsp_ff.rear, rsp_ff.front, rsp_ff.popped};

endmodule

`default_nettype wire

>>> rtl/adq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module adq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/adq_core.sv
// Deque control: head/tail pointers, count, cached end words, store access.
// Depends on adq_pkg; drives one adq_ram instance from the top level.
`default_nettype none

module adq_core
   import adq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire mode_type   req_mode,
   input  wire word_type   req_item,
   input  wire logic       out_free,
   output logic            res_valid,
   output result_type      res,
   output logic            wr_en,
   output idx_type         wr_addr,
   output word_type        wr_data,
   output logic            rd_en,
   output idx_type         rd_addr,
   input  wire word_type   rd_data
);

   state_type  state_ff,  state_in;
   idx_type    head_ff,   head_in;
   idx_type    tail_ff,   tail_in;
   cnt_type    count_ff,  count_in;
   word_type   front_ff,  front_in;
   word_type   rear_ff,   rear_in;
   word_type   popped_ff, popped_in;
   status_type status_ff, status_in;
   logic       side_ff,   side_in;   // 1: refetching the front word
   logic       accept;
   logic       is_full;
   logic       is_empty;
   cnt_type    count_dec;

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Next-state and store access
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      side_in   = side_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;
      wr_data   = req_item;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      res_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               popped_in = '0;
               status_in = STATUS_OK;
               res_valid = 1'b1;
               unique case (req_mode)
                  MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = STATUS_OVERFLOW;
                     end else if (is_empty) begin
                        // first word lands under the tail; both ends see it
                        wr_en    = 1'b1;
                        wr_addr  = tail_ff;
                        head_in  = tail_ff;
                        front_in = req_item;
                        rear_in  = req_item;
                        count_in = CNT_W'(1);
                     end else if (req_mode == MODE_PUSH_REAR) begin
                        wr_en    = 1'b1;
                        wr_addr  = idx_next(tail_ff);
                        tail_in  = idx_next(tail_ff);
                        rear_in  = req_item;
                        count_in = count_ff + 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = idx_prev(head_ff);
                        head_in  = idx_prev(head_ff);
                        front_in = req_item;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_POP_FRONT, MODE_POP_REAR: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_dec;
                        if (req_mode == MODE_POP_FRONT) begin
                           popped_in = front_ff;
                        end else begin
                           popped_in = rear_ff;
                        end
                        // more words left: fetch the new end word first
                        if (count_dec != '0) begin
                           res_valid = 1'b0;
                           rd_en     = 1'b1;
                           state_in  = ST_FETCH;
                           side_in   = (req_mode == MODE_POP_FRONT);
                           if (req_mode == MODE_POP_FRONT) begin
                              head_in = idx_next(head_ff);
                              rd_addr = idx_next(head_ff);
                           end else begin
                              tail_in = idx_prev(tail_ff);
                              rd_addr = idx_prev(tail_ff);
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            // store data for the new end word is back
            res_valid = 1'b1;
            state_in  = ST_IDLE;
            if (side_ff) begin
               front_in = rd_data;
            end else begin
               rear_in = rd_data;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result built from the post-operation state
   always_comb begin
      res.status    = status_in;
      res.popped    = popped_in;
      res.front     = (count_in == '0) ? NONE_WORD : front_in;
      res.rear      = (count_in == '0) ? NONE_WORD : rear_in;
      res.occupancy = OCC_W'(count_in);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      front_ff  <= front_in;
      rear_ff   <= rear_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      side_ff   <= side_in;
   end

endmodule

`default_nettype wire

>>> tb/array_deque_engine_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for array_deque_engine_unit: directed and random deque requests,
// results checked against an in-bench model of the circular store. Depends on adq_pkg.

module array_deque_engine_unit_test;
   import adq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_CYCLES = 80;

   typedef struct {
      mode_type mode;
      word_type item;
   } deque_op_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [TUSER_W-1:0]     req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [TUSER_W-1:0]     rsp_tuser;

   deque_op_type queued_ops[$];    // requests waiting for the driver
   result_type   due_results[$];   // results the block still owes
   deque_op_type offered_op;       // request currently on the bus

   // Model of the deque: store, front/rear slots, word count
   word_type    model_store [DEPTH];
   int unsigned model_head;
   int unsigned model_tail;
   int unsigned model_count;

   int mismatch_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   bit start_stall;
   bit hold_rsp;

   array_deque_engine_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Apply one request to the model and queue the result it must produce
   function automatic void apply_deque_op(input deque_op_type op);
      result_type r;
      r.status = STATUS_OK;
      r.popped = '0;
      case (op.mode)
         MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
            if (model_count >= DEPTH) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               // first word lands under the tail slot for either push
               if (model_count == 0) begin
                  model_head = model_tail;
               end else if (op.mode == MODE_PUSH_REAR) begin
                  model_tail = (model_tail + 1) % DEPTH;
               end else begin
                  model_head = (model_head + DEPTH - 1) % DEPTH;
               end
               if (op.mode == MODE_PUSH_FRONT) begin
                  model_store[model_head] = op.item;
               end else begin
                  model_store[model_tail] = op.item;
               end
               model_count++;
            end
         end
         default: begin
            if (model_count == 0) begin
               r.status = STATUS_EMPTY;
            end else if (op.mode == MODE_POP_FRONT) begin
               r.popped = model_store[model_head];
               model_count--;
               if (model_count != 0) model_head = (model_head + 1) % DEPTH;
            end else begin
               r.popped = model_store[model_tail];
               model_count--;
               if (model_count != 0) model_tail = (model_tail + DEPTH - 1) % DEPTH;
            end
         end
      endcase
      if (model_count == 0) begin
         r.front = NONE_WORD;
         r.rear  = NONE_WORD;
      end else begin
         r.front = model_store[model_head];
         r.rear  = model_store[model_tail];
      end
      r.occupancy = OCC_W'(model_count);
      due_results.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h, wanted %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_op(input mode_type m, input word_type w);
      deque_op_type op;
      op.mode = m;
      op.item = w;
      queued_ops.push_back(op);
   endtask

   // Random requests in bursts that lean to pushes, pops or neither,
   // so the deque runs full and empty again and again
   task automatic add_random_ops(input int n);
      int       push_pct;
      int       burst_left;
      int       pick;
      mode_type m;
      word_type w;
      burst_left = 0;
      push_pct   = 50;
      repeat (n) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(30, 6);
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         burst_left--;
         if ($urandom_range(99) < push_pct) begin
            m = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
         end else begin
            m = $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
         end
         pick = $urandom_range(9);
         case (pick)
            0: w = 32'h8000_0000;
            1: w = 32'h7FFF_FFFF;
            2: w = '1;
            3: w = '0;
            default: w = $urandom;
         endcase
         queue_op(m, w);
      end
   endtask

   // Wait until every request is taken and every result has come back
   task automatic wait_idle();
      @(negedge clock);
      while (queued_ops.size() != 0 || req_tvalid || due_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Request driver: predicts on acceptance, then offers the next request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_deque_op(offered_op);
         if (!req_tvalid || req_tready) begin
            if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_op = queued_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_TDATA_W'(offered_op.item);
               req_tuser  <= offered_op.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each result with the oldest prediction
   always @(posedge clock) begin : result_watch
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report_mismatch("unrequested result, popped", rsp_tdata[31:0], '0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[31:0] !== want.popped)
                  report_mismatch("popped", rsp_tdata[31:0], want.popped);
               if (rsp_tdata[63:32] !== want.front)
                  report_mismatch("front", rsp_tdata[63:32], want.front);
               if (rsp_tdata[95:64] !== want.rear)
                  report_mismatch("rear", rsp_tdata[95:64], want.rear);
               if (rsp_tdata[100:96] !== want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_tdata[100:96]), 32'(want.occupancy));
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input
   initial begin
      wait (start_stall);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      hold_rsp       = 1'b0;
      start_stall    = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      model_head     = 0;
      model_tail     = 0;
      model_count    = 0;
      send_idle_pct  = 19;
      recv_idle_pct  = 88;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: pops on empty, extremes, last-word pop, fill, overflow
      queue_op(MODE_POP_FRONT, 32'h1234_5678);
      queue_op(MODE_POP_REAR, '1);
      queue_op(MODE_PUSH_REAR, 32'h7FFF_FFFF);
      queue_op(MODE_PUSH_FRONT, 32'h8000_0000);
      queue_op(MODE_POP_FRONT, '0);
      queue_op(MODE_POP_REAR, '0);
      queue_op(MODE_PUSH_FRONT, '1);
      for (i = 0; i < DEPTH - 1; i++) begin
         queue_op(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
                  i[1] ? ~(32'h1 << i) : (32'hA5A5_0000 | 32'(i)));
      end
      queue_op(MODE_PUSH_REAR, 32'h0BAD_0001);
      queue_op(MODE_PUSH_FRONT, 32'h0BAD_0002);
      queue_op(MODE_POP_REAR, '0);

      // Sender idles a little, receiver a lot
      add_random_ops(140);
      wait_idle();

      // Sender idles a lot, receiver a little
      send_idle_pct = 88;
      recv_idle_pct = 19;
      add_random_ops(140);
      wait_idle();

      // No idling, with one long receiver stall
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_ops(120);
      start_stall = 1'b1;
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/adq_pkg.sv
rtl/adq_ram.sv
rtl/adq_core.sv
rtl/array_deque_engine_unit.sv
tb/array_deque_engine_unit_test.sv
